// ===== src/cpdbc_pkg.sv =====
`timescale 1ns / 1ps

package cpdbc_pkg;

    // Field and datapath widths
    localparam int GAIN_W  = 16;
    localparam int SMP_W   = 16;
    localparam int TGT_W   = 24;
    localparam int DRV_W   = 16;
    localparam int OPA_W   = 25;
    localparam int PROD_W  = OPA_W + GAIN_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int Q_BITS  = 12;
    localparam int CFG_IDX_W = 8;

    // Outer loop update divider default
    localparam int OUTER_DIVIDE_DEF = 6;

    // Filter coefficients, Q4.12 (0.3 and 0.7)
    localparam logic signed [GAIN_W-1:0] COEF_KEEP = 16'sd1229;
    localparam logic signed [GAIN_W-1:0] COEF_NEW  = 16'sd2867;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_PROP = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_RATE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_PROP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIFF = 8'd3;

    // Register reset values
    localparam logic signed [GAIN_W-1:0] RST_OUTER_PROP = 16'sd22118;
    localparam logic signed [GAIN_W-1:0] RST_OUTER_RATE = -16'sd1556;
    localparam logic signed [GAIN_W-1:0] RST_INNER_PROP = 16'sd410;
    localparam logic signed [GAIN_W-1:0] RST_INNER_DIFF = 16'sd0;

    typedef struct packed {
        logic signed [SMP_W-1:0] tilt_angle;
        logic signed [SMP_W-1:0] angular_rate;
    } t_in_item;

    typedef struct packed {
        logic signed [DRV_W-1:0] drive_value;
        logic signed [TGT_W-1:0] rate_target;
        logic                    saturated;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OUT_A,
        S_OUT_B,
        S_OUT_W,
        S_IN_A,
        S_IN_B,
        S_IN_W,
        S_DR_A,
        S_DR_B,
        S_DONE
    } t_seq_state;

    typedef enum logic [2:0] {
        OP_ANGLE,
        OP_RATE,
        OP_PREV,
        OP_TGT_ERR,
        OP_ERR,
        OP_ERR_DIFF
    } t_op_sel;

    typedef struct packed {
        logic en;
        logic clr;
    } t_mac_ctrl;

    typedef struct packed {
        t_mac_ctrl mac;
        t_op_sel   op;
        logic      wr_target;
        logic      wr_err;
        logic      wr_out;
    } t_seq_ctrl;

endpackage

// ===== src/cpdbc_mac.sv =====
`timescale 1ns / 1ps

module cpdbc_mac
    import cpdbc_pkg::*;
(
    input  logic                    i_clk,
    input  t_mac_ctrl               i_ctrl,
    input  logic signed [OPA_W-1:0]  i_a,
    input  logic signed [GAIN_W-1:0] i_b,
    output logic signed [TGT_W-1:0]  o_t24,
    output logic                    o_t24_sat,
    output logic signed [DRV_W-1:0]  o_d16,
    output logic                    o_d16_sat
);

    localparam int Q_W = ACC_W - Q_BITS;
    localparam int T_HI_I = 2**(TGT_W-1) - 1;
    localparam int D_HI_I = 2**(DRV_W-1) - 1;
    localparam logic signed [Q_W-1:0]   T_HI = Q_W'(T_HI_I);
    localparam logic signed [Q_W-1:0]   T_LO = Q_W'(-T_HI_I - 1);
    localparam logic signed [Q_W-1:0]   D_HI = Q_W'(D_HI_I);
    localparam logic signed [Q_W-1:0]   D_LO = Q_W'(-D_HI_I - 1);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2**(Q_BITS-1));

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [ACC_W-1:0]  w_base;
    logic signed [ACC_W-1:0]  w_rsum;
    logic signed [Q_W-1:0]    w_q;

    // Multiply and accumulate
    assign w_prod = i_a * i_b;
    assign w_base = i_ctrl.clr ? '0 : r_acc;
    assign n_acc  = w_base + ACC_W'(w_prod);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_acc <= n_acc;
        end
    end

    // Round to nearest, ties up, then drop the fraction
    assign w_rsum = r_acc + RND_HALF;
    assign w_q    = w_rsum[ACC_W-1:Q_BITS];

    // Clip to target width
    always_comb begin
        o_t24_sat = 1'b0;
        if (w_q > T_HI) begin
            o_t24     = TGT_W'(T_HI);
            o_t24_sat = 1'b1;
        end else if (w_q < T_LO) begin
            o_t24     = TGT_W'(T_LO);
            o_t24_sat = 1'b1;
        end else begin
            o_t24 = TGT_W'(w_q);
        end
    end

    // Clip to drive width
    always_comb begin
        o_d16_sat = 1'b0;
        if (w_q > D_HI) begin
            o_d16     = DRV_W'(D_HI);
            o_d16_sat = 1'b1;
        end else if (w_q < D_LO) begin
            o_d16     = DRV_W'(D_LO);
            o_d16_sat = 1'b1;
        end else begin
            o_d16 = DRV_W'(w_q);
        end
    end

endmodule

// ===== src/cpdbc_seq.sv =====
`timescale 1ns / 1ps

module cpdbc_seq
    import cpdbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_fire,
    input  logic      i_upd,
    input  logic      i_out_free,
    output logic      o_in_ready,
    output t_seq_ctrl o_ctrl
);

    t_seq_state r_state;
    t_seq_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance through the product steps
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    n_state = i_upd ? S_OUT_A : S_IN_A;
                end
            end
            S_OUT_A: n_state = S_OUT_B;
            S_OUT_B: n_state = S_OUT_W;
            S_OUT_W: n_state = S_IN_A;
            S_IN_A:  n_state = S_IN_B;
            S_IN_B:  n_state = S_IN_W;
            S_IN_W:  n_state = S_DR_A;
            S_DR_A:  n_state = S_DR_B;
            S_DR_B:  n_state = S_DONE;
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Drive the datapath controls
    always_comb begin
        o_ctrl     = '0;
        o_ctrl.op  = OP_ANGLE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: o_in_ready = 1'b1;
            S_OUT_A: begin
                o_ctrl.mac = '{en: 1'b1, clr: 1'b1};
                o_ctrl.op  = OP_ANGLE;
            end
            S_OUT_B: begin
                o_ctrl.mac = '{en: 1'b1, clr: 1'b0};
                o_ctrl.op  = OP_RATE;
            end
            S_OUT_W: o_ctrl.wr_target = 1'b1;
            S_IN_A: begin
                o_ctrl.mac = '{en: 1'b1, clr: 1'b1};
                o_ctrl.op  = OP_PREV;
            end
            S_IN_B: begin
                o_ctrl.mac = '{en: 1'b1, clr: 1'b0};
                o_ctrl.op  = OP_TGT_ERR;
            end
            S_IN_W: o_ctrl.wr_err = 1'b1;
            S_DR_A: begin
                o_ctrl.mac = '{en: 1'b1, clr: 1'b1};
                o_ctrl.op  = OP_ERR;
            end
            S_DR_B: begin
                o_ctrl.mac = '{en: 1'b1, clr: 1'b0};
                o_ctrl.op  = OP_ERR_DIFF;
            end
            S_DONE: o_ctrl.wr_out = i_out_free;
            default: o_ctrl = '0;
        endcase
    end

endmodule

// ===== src/cascaded_pd_balance_controller.sv =====
// One shared 25x16 MAC runs two products per stage (target, filtered error,
// drive); target and error each get a write state, and the drive result is
// loaded once the output is free. The target stage runs only on outer update
// ticks. A new input beat is taken only after the last result is loaded.
// Reset (synchronous, active low) clears the sequencer, tick counter, held
// target, filtered error and output valid, and reloads the gain registers.
`timescale 1ns / 1ps

module cascaded_pd_balance_controller
    import cpdbc_pkg::*;
#(
    parameter int OUTER_DIVIDE = OUTER_DIVIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [GAIN_W-1:0]     i_cfg_data
);

    localparam int TW = (OUTER_DIVIDE > 1) ? $clog2(OUTER_DIVIDE) : 1;

    logic signed [GAIN_W-1:0] r_g_outer_prop;
    logic signed [GAIN_W-1:0] r_g_outer_rate;
    logic signed [GAIN_W-1:0] r_g_inner_prop;
    logic signed [GAIN_W-1:0] r_g_inner_diff;

    logic [TW-1:0]            r_tick;
    logic [TW-1:0]            n_tick;
    logic [TW:0]              w_tick_inc;
    logic                     w_upd;

    logic signed [SMP_W-1:0]  r_angle;
    logic signed [SMP_W-1:0]  r_rate;
    logic signed [TGT_W-1:0]  r_target;
    logic signed [TGT_W-1:0]  r_ferr;
    logic signed [TGT_W-1:0]  r_prev_err;
    logic                     r_sat;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     w_in_fire;
    logic                     w_out_fire;
    logic                     w_out_free;
    t_seq_ctrl                w_ctrl;

    logic signed [OPA_W-1:0]  w_a;
    logic signed [GAIN_W-1:0] w_b;
    logic signed [TGT_W-1:0]  w_t24;
    logic                     w_t24_sat;
    logic signed [DRV_W-1:0]  w_d16;
    logic                     w_d16_sat;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_fire = r_out_valid && i_out_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    // Write gain registers; ignore unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_outer_prop <= RST_OUTER_PROP;
            r_g_outer_rate <= RST_OUTER_RATE;
            r_g_inner_prop <= RST_INNER_PROP;
            r_g_inner_diff <= RST_INNER_DIFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OUTER_PROP: r_g_outer_prop <= i_cfg_data;
                REG_OUTER_RATE: r_g_outer_rate <= i_cfg_data;
                REG_INNER_PROP: r_g_inner_prop <= i_cfg_data;
                REG_INNER_DIFF: r_g_inner_diff <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Count ticks toward the next outer update
    assign w_tick_inc = {1'b0, r_tick} + 1'b1;
    assign w_upd      = w_tick_inc >= (TW+1)'(OUTER_DIVIDE);
    assign n_tick     = w_upd ? '0 : w_tick_inc[TW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
        end else if (w_in_fire) begin
            r_tick <= n_tick;
        end
    end

    // Capture the sample beat
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_angle <= i_in_data.tilt_angle;
            r_rate  <= i_in_data.angular_rate;
        end
    end

    // Select MAC operands
    always_comb begin
        case (w_ctrl.op)
            OP_ANGLE: begin
                w_a = -OPA_W'(r_angle);
                w_b = r_g_outer_prop;
            end
            OP_RATE: begin
                w_a = OPA_W'(r_rate);
                w_b = r_g_outer_rate;
            end
            OP_PREV: begin
                w_a = OPA_W'(r_ferr);
                w_b = COEF_KEEP;
            end
            OP_TGT_ERR: begin
                w_a = OPA_W'(r_target) - OPA_W'(r_rate);
                w_b = COEF_NEW;
            end
            OP_ERR: begin
                w_a = OPA_W'(r_ferr);
                w_b = r_g_inner_prop;
            end
            OP_ERR_DIFF: begin
                w_a = OPA_W'(r_ferr) - OPA_W'(r_prev_err);
                w_b = r_g_inner_diff;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    cpdbc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_upd      (w_upd),
        .i_out_free (w_out_free),
        .o_in_ready (o_in_ready),
        .o_ctrl     (w_ctrl)
    );

    cpdbc_mac u_mac (
        .i_clk     (i_clk),
        .i_ctrl    (w_ctrl.mac),
        .i_a       (w_a),
        .i_b       (w_b),
        .o_t24     (w_t24),
        .o_t24_sat (w_t24_sat),
        .o_d16     (w_d16),
        .o_d16_sat (w_d16_sat)
    );

    // Hold loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= '0;
            r_ferr     <= '0;
            r_prev_err <= '0;
            r_sat      <= 1'b0;
        end else begin
            if (w_in_fire) begin
                r_sat <= 1'b0;
            end
            if (w_ctrl.wr_target) begin
                r_target <= w_t24;
                r_sat    <= r_sat | w_t24_sat;
            end
            if (w_ctrl.wr_err) begin
                r_prev_err <= r_ferr;
                r_ferr     <= w_t24;
                r_sat      <= r_sat | w_t24_sat;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (w_ctrl.wr_out) begin
            r_out.drive_value <= w_d16;
            r_out.rate_target <= r_target;
            r_out.saturated   <= r_sat | w_d16_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.wr_out) begin
            r_out_valid <= 1'b1;
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_tick} < (TW+1)'(OUTER_DIVIDE))
        else $error("tick counter out of range");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> !o_in_ready)
        else $error("input ready while a tick is in work");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_ctrl.wr_out))
        else $error("result beat without a drive write");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.wr_out |-> w_out_free)
        else $error("pending result overwritten");

    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_ctrl.wr_target, w_ctrl.wr_err, w_ctrl.wr_out, w_in_fire}))
        else $error("overlapping sequencer writes");

endmodule
